// ===== design/mei_pkg.sv =====
`default_nettype none

package mei_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 24;
    localparam int MAG_WIDTH   = DATA_WIDTH - 1;
    localparam int LIMIT_WIDTH = 16;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(256);

    typedef logic signed [DATA_WIDTH-1:0] fx_t;
    typedef logic [MAG_WIDTH-1:0]         ufx_t;
    typedef logic [LIMIT_WIDTH-1:0]       count_t;

    typedef struct packed {
        logic load;
        logic step_add;
        logic step_mul;
        logic step_sat;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/mei_channels.sv =====
`default_nettype none

interface mei_point_if;
    logic              valid;
    logic              ready;
    mei_pkg::fx_t      c_real;
    mei_pkg::fx_t      c_imag;

    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mei_result_if;
    logic              valid;
    logic              ready;
    mei_pkg::count_t   iterations;
    mei_pkg::ufx_t     real_squared;
    mei_pkg::ufx_t     imag_squared;

    modport source (output valid, output iterations, output real_squared,
                    output imag_squared, input ready);
    modport sink   (input valid, input iterations, input real_squared,
                    input imag_squared, output ready);
endinterface

interface mei_cfg_if;
    logic              valid;
    logic              ready;
    mei_pkg::count_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/mandelbrot_escape_iterator_top.sv =====
// Mandelbrot escape-time iterator.
// The point channel carries c = c_real + i*c_imag in signed Q8.24. The result
// channel returns the iteration count and the final x squared and y squared,
// each saturated to the positive Q8.24 range. The cfg channel writes the
// iteration limit and is always ready; write it only while no point is in work.
// Each iteration runs the saturating adds that form x and y, then the three
// parallel 32 by 32 squarings, then the scaling back to Q8.24.
// The controller is ready for the next point in the same cycle that the
// result becomes valid.
// Only one point is in work at a time; throughput is set by the single
// iteration loop through the squaring unit.
// The result sits in an output register, so a new point is accepted while an
// earlier result still waits; a finished point waits in the controller only
// when that register is still full and the receiver is stalling.
// Reset sets the iteration limit to 256 and clears all pending work.
`default_nettype none

module mandelbrot_escape_iterator_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mei_point_if.sink   point,
    mei_result_if.source result,
    mei_cfg_if.sink     cfg
);
    import mei_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    mei_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (point.valid),
        .in_ready (point.ready),
        .status   (status),
        .cmd      (cmd)
    );

    mei_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .c_real       (point.c_real),
        .c_imag       (point.c_imag),
        .cfg_valid    (cfg.valid),
        .cfg_data     (cfg.data),
        .res_ready    (result.ready),
        .res_valid    (result.valid),
        .iterations   (result.iterations),
        .real_squared (result.real_squared),
        .imag_squared (result.imag_squared)
    );

endmodule

`default_nettype wire

// ===== design/mei_ctrl.sv =====
`default_nettype none

module mei_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire mei_pkg::dp_status_t status,
    output mei_pkg::dp_cmd_t         cmd
);
    import mei_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_MUL,
        ST_SAT,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (status.done)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.step_add = 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.step_mul = 1'b1;
                state_next   = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.step_sat = 1'b1;
                state_next   = ST_ADD;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("More than one datapath command in one cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_ADD)
        else $error("A loaded point did not start iterating.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_mul |=> cmd.step_sat)
        else $error("Squares were not scaled after the multiply.");

endmodule

`default_nettype wire

// ===== design/mei_datapath.sv =====
`default_nettype none

module mei_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mei_pkg::dp_cmd_t    cmd,
    output mei_pkg::dp_status_t      status,
    input  wire mei_pkg::fx_t        c_real,
    input  wire mei_pkg::fx_t        c_imag,
    input  wire logic                cfg_valid,
    input  wire mei_pkg::count_t     cfg_data,
    input  wire logic                res_ready,
    output logic                     res_valid,
    output mei_pkg::count_t          iterations,
    output mei_pkg::ufx_t            real_squared,
    output mei_pkg::ufx_t            imag_squared
);
    import mei_pkg::*;

    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int Q_WIDTH    = PROD_WIDTH - FRAC_BITS;

    localparam logic [DATA_WIDTH-1:0] FOUR_FX  = DATA_WIDTH'(4) << FRAC_BITS;
    localparam logic [MAG_WIDTH-1:0]  SMAX     = '1;

    function automatic fx_t sat_add(input fx_t a, input fx_t b);
        logic signed [DATA_WIDTH:0] sum;
        sum = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        if (sum[DATA_WIDTH] != sum[DATA_WIDTH-1])
        begin
            return sum[DATA_WIDTH] ? {1'b1, {MAG_WIDTH{1'b0}}} : {1'b0, SMAX};
        end
        return sum[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [DATA_WIDTH-1:0] magnitude(input fx_t a);
        return a[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - a) : a;
    endfunction

    function automatic ufx_t scale_sat(input logic [PROD_WIDTH-1:0] p);
        logic [Q_WIDTH-1:0] q;
        q = p[PROD_WIDTH-1:FRAC_BITS];
        if (|q[Q_WIDTH-1:MAG_WIDTH])
        begin
            return SMAX;
        end
        return q[MAG_WIDTH-1:0];
    endfunction

    fx_t                   cr_reg, ci_reg;
    ufx_t                  xx_reg, yy_reg, ww_reg;
    fx_t                   x_reg, y_reg;
    logic [PROD_WIDTH-1:0] pxx_reg, pyy_reg, pww_reg;
    count_t                n_reg;
    count_t                limit_reg;
    logic                  out_valid_reg;
    count_t                out_n_reg;
    ufx_t                  out_xx_reg, out_yy_reg;

    fx_t                   neg_xx, neg_yy, x_next, y_next, s_sum;
    logic [DATA_WIDTH-1:0] mx, my, ms;
    logic [DATA_WIDTH-1:0] mod_sq;

    always_comb
    begin
        neg_xx = DATA_WIDTH'(0) - fx_t'({1'b0, xx_reg});
        neg_yy = DATA_WIDTH'(0) - fx_t'({1'b0, yy_reg});
        x_next = sat_add(sat_add(fx_t'({1'b0, xx_reg}), neg_yy), cr_reg);
        y_next = sat_add(sat_add(sat_add(fx_t'({1'b0, ww_reg}), neg_xx), neg_yy),
                         ci_reg);
        s_sum  = sat_add(x_reg, y_reg);
        mx     = magnitude(x_reg);
        my     = magnitude(y_reg);
        ms     = magnitude(s_sum);
        mod_sq = {1'b0, xx_reg} + {1'b0, yy_reg};
    end

    assign status = '{done:     (mod_sq > FOUR_FX) || (n_reg >= limit_reg),
                      out_free: !out_valid_reg || res_ready};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cr_reg <= c_real;
            ci_reg <= c_imag;
            xx_reg <= '0;
            yy_reg <= '0;
            ww_reg <= '0;
            n_reg  <= '0;
        end
        if (cmd.step_add)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
        if (cmd.step_mul)
        begin
            pxx_reg <= mx * mx;
            pyy_reg <= my * my;
            pww_reg <= ms * ms;
        end
        if (cmd.step_sat)
        begin
            xx_reg <= scale_sat(pxx_reg);
            yy_reg <= scale_sat(pyy_reg);
            ww_reg <= scale_sat(pww_reg);
            n_reg  <= n_reg + LIMIT_WIDTH'(1);
        end
        if (cmd.emit)
        begin
            out_n_reg  <= n_reg;
            out_xx_reg <= xx_reg;
            out_yy_reg <= yy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid    = out_valid_reg;
    assign iterations   = out_n_reg;
    assign real_squared = out_xx_reg;
    assign imag_squared = out_yy_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> n_reg == '0 && xx_reg == '0 && yy_reg == '0)
        else $error("Iteration state was not cleared for a new point.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_sat |=> n_reg <= limit_reg)
        else $error("Iteration count ran past the limit.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> res_valid && iterations == $past(n_reg))
        else $error("Result register did not capture the final count.");

endmodule

`default_nettype wire
